// ===== src/ndp_pkg.sv =====
// ----------------------------------------------------------------------------
// ndp_pkg
// Shared widths, constants and types of the normalized dot product unit.
// ----------------------------------------------------------------------------
package ndp_pkg;

	localparam int WEIGHT_W = 16;
	localparam int VALUE_W  = 16;
	localparam int RESP_W   = 16;
	localparam int PROD_W   = WEIGHT_W + VALUE_W + 1;
	localparam int SQ_W     = 2 * VALUE_W;
	localparam int DOT_W    = 41;
	localparam int ENERGY_W = 40;
	localparam int ROOT_W   = ENERGY_W / 2;
	localparam int NUM_W    = DOT_W + 1;
	localparam int UNIT_W   = NUM_W - RESP_W;
	localparam int REM_W    = ROOT_W + 1;
	localparam int STEP_W   = 5;

	localparam int SQRT_STEPS = ROOT_W;
	localparam int DIV_STEPS  = RESP_W;

	localparam logic [RESP_W-1:0] RESP_SAT = {RESP_W{1'b1}};

	// finished window handed from the accumulator to the root/divide sequencer
	typedef struct packed {
		logic                       valid;
		logic                       unknown;
		logic signed [DOT_W-1:0]    dot;
		logic [ENERGY_W-1:0]        energy;
	} win_t;

endpackage

// ===== src/ndp_if.sv =====
// ----------------------------------------------------------------------------
// ndp_if
// Valid/ready channels of the normalized dot product unit: window elements
// in, responses out.
// ----------------------------------------------------------------------------
interface ndp_in_if;
	import ndp_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [WEIGHT_W-1:0] weight;
	logic [VALUE_W-1:0]         value;
	logic                       value_unknown;
	logic                       window_outside;
	logic                       last_element;

	modport source (
		output valid, weight, value, value_unknown, window_outside, last_element,
		input  ready
	);
	modport sink (
		input  valid, weight, value, value_unknown, window_outside, last_element,
		output ready
	);
endinterface

interface ndp_out_if;
	import ndp_pkg::*;

	logic               valid;
	logic               ready;
	logic [RESP_W-1:0]  response;
	logic               unknown;

	modport source (
		output valid, response, unknown,
		input  ready
	);
	modport sink (
		input  valid, response, unknown,
		output ready
	);
endinterface

// ===== src/ndp_accum.sv =====
// ----------------------------------------------------------------------------
// ndp_accum
// Window accumulator: multiplies each element, sums the dot product and the
// energy of the first MAX_WINDOW_ELEMENTS, saturating; hands the window on.
// ----------------------------------------------------------------------------
module ndp_accum #(
	parameter int MAX_WINDOW_ELEMENTS = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	ndp_in_if.sink       in_ch,
	output ndp_pkg::win_t win,
	input  logic         take
);
	import ndp_pkg::*;

	localparam int CNT_W = $clog2(MAX_WINDOW_ELEMENTS + 1);

	logic                      accept;
	logic [CNT_W-1:0]          cnt_q;

	logic                      valid_s1;
	logic                      acc_s1;
	logic                      last_s1;
	logic                      flag_s1;
	logic signed [PROD_W-1:0]  prod_s1;
	logic [SQ_W-1:0]           sq_s1;

	logic signed [DOT_W-1:0]   dot_q;
	logic [ENERGY_W-1:0]       energy_q;
	logic                      unk_q;
	logic                      win_valid_q;

	logic signed [DOT_W:0]     dot_sum;
	logic [ENERGY_W:0]         energy_sum;
	logic signed [DOT_W-1:0]   dot_next;
	logic [ENERGY_W-1:0]       energy_next;

	// hold off from the beat after a last element until the window is taken
	assign in_ch.ready = !(valid_s1 && last_s1) && !win_valid_q;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			acc_s1   <= 1'b0;
			last_s1  <= 1'b0;
			flag_s1  <= 1'b0;
			cnt_q    <= '0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				acc_s1  <= cnt_q < CNT_W'(MAX_WINDOW_ELEMENTS);
				last_s1 <= in_ch.last_element;
				flag_s1 <= in_ch.value_unknown || in_ch.window_outside;
				if (cnt_q < CNT_W'(MAX_WINDOW_ELEMENTS)) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (take) begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1 <= $signed(in_ch.weight) * $signed({1'b0, in_ch.value});
			sq_s1   <= in_ch.value * in_ch.value;
		end
	end

	always_comb begin
		dot_sum    = {dot_q[DOT_W-1], dot_q}
			+ {{(DOT_W + 1 - PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		energy_sum = {1'b0, energy_q} + (ENERGY_W + 1)'(sq_s1);
		if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) begin
			dot_next = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}}
				: {1'b0, {(DOT_W-1){1'b1}}};
		end else begin
			dot_next = dot_sum[DOT_W-1:0];
		end
		energy_next = energy_sum[ENERGY_W] ? {ENERGY_W{1'b1}} : energy_sum[ENERGY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q       <= '0;
			energy_q    <= '0;
			unk_q       <= 1'b0;
			win_valid_q <= 1'b0;
		end else if (take) begin
			dot_q       <= '0;
			energy_q    <= '0;
			unk_q       <= 1'b0;
			win_valid_q <= 1'b0;
		end else if (valid_s1) begin
			if (acc_s1) begin
				dot_q    <= dot_next;
				energy_q <= energy_next;
			end
			unk_q <= unk_q || flag_s1;
			if (last_s1) begin
				win_valid_q <= 1'b1;
			end
		end
	end

	assign win.valid   = win_valid_q;
	assign win.unknown = unk_q;
	assign win.dot     = dot_q;
	assign win.energy  = energy_q;

	a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		win_valid_q |-> !in_ch.ready)
		else $error("element accepted while a finished window is pending");

	a_take_only_pending: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> win_valid_q)
		else $error("window taken that was not finished");

	a_cleared_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> dot_q == '0 && energy_q == '0 && !unk_q && cnt_q == '0)
		else $error("window state not cleared after hand-off");

	a_last_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 |=> !valid_s1 && win_valid_q)
		else $error("beat accepted behind a last element");

endmodule

// ===== src/ndp_root_div.sv =====
// ----------------------------------------------------------------------------
// ndp_root_div
// Sequencer around one shared subtract/compare unit: integer square root of
// the energy, a saturation check, then restoring division of 2*|dot| by the
// root. Holds the response in the output register.
// ----------------------------------------------------------------------------
module ndp_root_div (
	input  logic          clk,
	input  logic          arst_n,
	input  ndp_pkg::win_t win,
	output logic          take,
	ndp_out_if.source     out_ch
);
	import ndp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_OVF,
		ST_DIV,
		ST_HOLD
	} state_t;

	state_t               state_q;
	logic [STEP_W-1:0]    step_q;
	logic [ENERGY_W-1:0]  rad_q;
	logic [REM_W-1:0]     rem_q;
	logic [ROOT_W-1:0]    root_q;
	logic [NUM_W-1:0]     num_q;
	logic [RESP_W-1:0]    quo_q;
	logic [RESP_W-1:0]    res_q;
	logic                 res_unk_q;
	logic                 out_valid_q;
	logic [RESP_W-1:0]    out_resp_q;
	logic                 out_unk_q;

	logic [UNIT_W-1:0]    unit_a;
	logic [UNIT_W-1:0]    unit_b;
	logic [UNIT_W:0]      unit_diff;
	logic                 unit_ge;
	logic [DOT_W-1:0]     mag;
	logic                 load_out;

	assign take     = (state_q == ST_IDLE) && win.valid;
	assign mag      = win.dot[DOT_W-1] ? DOT_W'(-win.dot) : DOT_W'(win.dot);
	assign load_out = (state_q == ST_HOLD) && (!out_valid_q || out_ch.ready);

	// the shared unit
	always_comb begin
		case (state_q)
			ST_SQRT: begin
				unit_a = UNIT_W'({rem_q, rad_q[ENERGY_W-1 -: 2]});
				unit_b = UNIT_W'({root_q, 2'b01});
			end
			ST_OVF: begin
				unit_a = num_q[NUM_W-1 -: UNIT_W];
				unit_b = UNIT_W'(root_q);
			end
			ST_DIV: begin
				unit_a = UNIT_W'({rem_q[ROOT_W-1:0], num_q[RESP_W-1]});
				unit_b = UNIT_W'(root_q);
			end
			default: begin
				unit_a = '0;
				unit_b = '0;
			end
		endcase
		unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
		unit_ge   = !unit_diff[UNIT_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			rad_q       <= '0;
			rem_q       <= '0;
			root_q      <= '0;
			num_q       <= '0;
			quo_q       <= '0;
			res_q       <= '0;
			res_unk_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_resp_q  <= '0;
			out_unk_q   <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (win.valid) begin
						res_q     <= '0;
						res_unk_q <= win.unknown;
						rad_q     <= win.energy;
						rem_q     <= '0;
						root_q    <= '0;
						num_q     <= {mag, 1'b0};
						step_q    <= STEP_W'(SQRT_STEPS - 1);
						if (win.unknown || win.energy == '0) begin
							state_q <= ST_HOLD;
						end else begin
							state_q <= ST_SQRT;
						end
					end
				end
				ST_SQRT: begin
					// remainder stays at most twice the partial root
					rem_q  <= unit_ge ? unit_diff[REM_W-1:0] : unit_a[REM_W-1:0];
					root_q <= {root_q[ROOT_W-2:0], unit_ge};
					rad_q  <= {rad_q[ENERGY_W-3:0], 2'b00};
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						state_q <= ST_OVF;
					end
				end
				ST_OVF: begin
					if (unit_ge) begin
						res_q   <= RESP_SAT;
						state_q <= ST_HOLD;
					end else begin
						rem_q   <= REM_W'(unit_a[ROOT_W-1:0]);
						step_q  <= STEP_W'(DIV_STEPS - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= unit_ge ? REM_W'(unit_diff[ROOT_W-1:0])
						: REM_W'(unit_a[ROOT_W-1:0]);
					quo_q  <= {quo_q[RESP_W-2:0], unit_ge};
					num_q  <= {num_q[NUM_W-2:0], 1'b0};
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						res_q   <= {quo_q[RESP_W-2:0], unit_ge};
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (load_out) begin
						out_resp_q  <= res_q;
						out_unk_q   <= res_unk_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.response = out_resp_q;
	assign out_ch.unknown  = out_unk_q;

	a_div_rem_below_root: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> !rem_q[REM_W-1] && rem_q[ROOT_W-1:0] < root_q)
		else $error("division remainder not below the root");

	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OVF |-> root_q != '0)
		else $error("zero root reached the divide");

	a_unknown_short_path: assert property (@(posedge clk) disable iff (!arst_n)
		take && win.unknown |=> state_q == ST_HOLD && res_unk_q && res_q == '0)
		else $error("unknown window did not bypass the root and divide");

	a_unknown_zero_resp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_unk_q |-> out_resp_q == '0)
		else $error("unknown result carries a nonzero response");

endmodule

// ===== src/normalized_dot_product_unit.sv =====
// ----------------------------------------------------------------------------
// normalized_dot_product_unit
// Accumulates weight*value and value^2 over a window of elements and emits
// |dot| / sqrt(energy) as unsigned Q15.1, saturated, or the unknown marker.
//
//   channel   dir  beat contents
//   in_ch     in   weight, value, value_unknown, window_outside, last_element
//   out_ch    out  response, unknown (one beat per last_element)
//
// Elements are taken one per cycle while the input is not held off, through a
// two-stage multiply/accumulate path. After a last element the input stalls
// while the window closes and is handed to the sequencer. The sequencer runs
// 20 square-root steps, one saturation check and 16 divide steps on one shared
// 26-bit subtract/compare unit, then one step to load the output; a saturated
// window skips the divide, unknown or zero-energy windows skip all but the load.
// A window that closes while the sequencer is busy holds the input off until
// the sequencer is idle again.
// A finished response waits in the output register; a stalled output holds
// the following window's result in the sequencer until the register frees.
// Reset is asynchronous and clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module normalized_dot_product_unit #(
	parameter int MAX_WINDOW_ELEMENTS = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	ndp_in_if.sink    in_ch,
	ndp_out_if.source out_ch
);
	import ndp_pkg::*;

	win_t win;
	logic take;

	ndp_accum #(
		.MAX_WINDOW_ELEMENTS (MAX_WINDOW_ELEMENTS)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.win    (win),
		.take   (take)
	);

	ndp_root_div u_root_div (
		.clk    (clk),
		.arst_n (arst_n),
		.win    (win),
		.take   (take),
		.out_ch (out_ch)
	);

endmodule

// ===== bench/normalized_dot_product_unit_test.sv =====
// ----------------------------------------------------------------------------
// normalized_dot_product_unit_test
// Streams windows of weight/value elements into the unit. A local model keeps
// the dot and energy sums and works out 2*|dot| / isqrt(energy) per window.
// Each response beat is compared with the oldest predicted response. Short
// directed windows come first, then random windows of varied length and
// content, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module normalized_dot_product_unit_test;
	import ndp_pkg::*;

	localparam int WINDOW_LIMIT   = 256;
	localparam int RANDOM_ITEMS   = 1950;
	localparam int DRAIN_CYCLES   = 80;

	localparam longint DOT_HI = (longint'(1) <<< (DOT_W - 1)) - 1;
	localparam longint DOT_LO = -(longint'(1) <<< (DOT_W - 1));
	localparam longint unsigned ENERGY_HI = (longint'(1) << ENERGY_W) - 1;
	localparam longint unsigned RESP_MAX  = (longint'(1) << RESP_W) - 1;

	typedef struct {
		logic signed [WEIGHT_W-1:0] weight;
		logic [VALUE_W-1:0]         value;
		logic                       value_unknown;
		logic                       window_outside;
		logic                       last_element;
	} element_t;

	typedef struct {
		logic [RESP_W-1:0] response;
		logic              unknown;
	} response_t;

	logic clk;
	logic arst_n;

	ndp_in_if  in_ch ();
	ndp_out_if out_ch ();

	normalized_dot_product_unit #(
		.MAX_WINDOW_ELEMENTS(WINDOW_LIMIT)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch.sink),
		.out_ch(out_ch.source)
	);

	element_t  element_queue[$];
	response_t expected_responses[$];

	// window state of the local model
	longint          win_dot;
	longint unsigned win_energy;
	bit              win_unknown;
	int              win_count;

	int elements_queued;
	int elements_taken;
	int mismatches;
	int windows_done;
	int unknown_windows;
	int zero_energy_windows;
	int saturated_windows;
	int overlong_windows;

	int in_gap;
	int in_calm_left;
	int out_stall;
	int out_calm_left;
	element_t beat;
	element_t next_beat;

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= x)
				root = trial;
		end
		return root;
	endfunction

	task automatic accumulate_element(input element_t e);
		longint          prod;
		longint          sum;
		longint unsigned sq;
		longint unsigned mag;
		longint unsigned quot;
		response_t       r;
		if (e.value_unknown || e.window_outside)
			win_unknown = 1'b1;
		if (win_count < WINDOW_LIMIT) begin
			prod = longint'(e.weight) * longint'({48'd0, e.value});
			sq   = longint'({48'd0, e.value}) * longint'({48'd0, e.value});
			sum  = win_dot + prod;
			if (sum > DOT_HI)
				sum = DOT_HI;
			if (sum < DOT_LO)
				sum = DOT_LO;
			win_dot    = sum;
			win_energy = win_energy + sq;
			if (win_energy > ENERGY_HI)
				win_energy = ENERGY_HI;
			win_count++;
		end else if (win_count == WINDOW_LIMIT) begin
			overlong_windows++;
			win_count++;
		end
		if (!e.last_element)
			return;
		r.response = '0;
		r.unknown  = 1'b0;
		if (win_unknown) begin
			r.unknown = 1'b1;
			unknown_windows++;
		end else if (win_energy == 0) begin
			zero_energy_windows++;
		end else begin
			mag  = (win_dot < 0) ? longint'(-win_dot) : longint'(win_dot);
			quot = (2 * mag) / int_sqrt(win_energy);
			if (quot >= RESP_MAX) begin
				quot = RESP_MAX;
				saturated_windows++;
			end
			r.response = quot[RESP_W-1:0];
		end
		expected_responses.push_back(r);
		windows_done++;
		win_dot     = 0;
		win_energy  = 0;
		win_unknown = 1'b0;
		win_count   = 0;
	endtask

	task automatic report_mismatch(input string what);
		$display("t=%0t mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic check_response(input logic [RESP_W-1:0] response, input logic unknown);
		response_t want;
		if (expected_responses.size() == 0) begin
			report_mismatch($sformatf("response %0d unknown %0b with none pending",
				response, unknown));
			return;
		end
		want = expected_responses.pop_front();
		if (response !== want.response)
			report_mismatch($sformatf("response got %0d want %0d", response, want.response));
		if (unknown !== want.unknown)
			report_mismatch($sformatf("unknown got %0b want %0b", unknown, want.unknown));
	endtask

	// most gaps short, a few long, none while a calm stretch lasts
	function automatic int draw_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic queue_element(input logic signed [WEIGHT_W-1:0] w,
			input logic [VALUE_W-1:0] v, input bit unk, input bit outside, input bit last);
		element_t e;
		e.weight         = w;
		e.value          = v;
		e.value_unknown  = unk;
		e.window_outside = outside;
		e.last_element   = last;
		element_queue.push_back(e);
		elements_queued++;
	endtask

	function automatic logic signed [WEIGHT_W-1:0] pick_weight(input int mode);
		case (mode)
			0: return WEIGHT_W'($urandom);
			1: return WEIGHT_W'($urandom_range(0, 510) - 255);
			2: begin
				case ($urandom_range(0, 4))
					0: return 16'sh8000;
					1: return 16'sh7FFF;
					2: return 16'sh0000;
					3: return 16'shFFFF;
					default: return 16'sh0001;
				endcase
			end
			default: return WEIGHT_W'($urandom_range(16384, 32767));
		endcase
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value(input int mode);
		case (mode)
			0: return VALUE_W'($urandom);
			1: return VALUE_W'($urandom_range(0, 255));
			2: return '0;
			3: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return 16'hFFFF;
					2: return 16'h0001;
					default: return 16'h8000;
				endcase
			end
			default: return VALUE_W'($urandom_range(49152, 65535));
		endcase
	endfunction

	task automatic queue_random_window(input int len, input int flag_at);
		int wmode;
		int vmode;
		int unk_pct;
		bit outside_win;
		bit unk;
		wmode       = $urandom_range(0, 3);
		vmode       = $urandom_range(0, 4);
		outside_win = ($urandom_range(0, 19) == 0);
		unk_pct     = ($urandom_range(0, 6) == 0) ? 10 : 0;
		for (int i = 0; i < len; i++) begin
			unk = ($urandom_range(0, 99) < unk_pct) || (i == flag_at);
			queue_element(pick_weight(wmode), pick_value(vmode), unk,
				outside_win && ($urandom_range(0, 3) == 0), i == len - 1);
		end
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid          <= 1'b0;
			in_ch.weight         <= '0;
			in_ch.value          <= '0;
			in_ch.value_unknown  <= 1'b0;
			in_ch.window_outside <= 1'b0;
			in_ch.last_element   <= 1'b0;
			in_gap        = 0;
			in_calm_left  = 0;
		end else begin
			if (in_calm_left > 0)
				in_calm_left--;
			else if ($urandom_range(0, 199) == 0)
				in_calm_left = $urandom_range(50, 300);
			if (in_ch.valid && in_ch.ready) begin
				beat.weight         = in_ch.weight;
				beat.value          = in_ch.value;
				beat.value_unknown  = in_ch.value_unknown;
				beat.window_outside = in_ch.window_outside;
				beat.last_element   = in_ch.last_element;
				accumulate_element(beat);
				elements_taken++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_ch.valid <= 1'b0;
				end else if (element_queue.size() > 0) begin
					next_beat = element_queue.pop_front();
					in_ch.weight         <= next_beat.weight;
					in_ch.value          <= next_beat.value;
					in_ch.value_unknown  <= next_beat.value_unknown;
					in_ch.window_outside <= next_beat.window_outside;
					in_ch.last_element   <= next_beat.last_element;
					in_ch.valid          <= 1'b1;
					in_gap = draw_gap(in_calm_left > 0);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			out_stall     = 0;
			out_calm_left = 0;
		end else begin
			if (out_calm_left > 0)
				out_calm_left--;
			else if ($urandom_range(0, 199) == 0)
				out_calm_left = $urandom_range(50, 300);
			if (out_ch.valid && out_ch.ready)
				check_response(out_ch.response, out_ch.unknown);
			if (out_stall == 0 && ((out_ch.valid && out_ch.ready) || $urandom_range(0, 9) == 0))
				out_stall = draw_gap(out_calm_left > 0);
			if (out_stall > 0) begin
				out_stall--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int r;
		int len;
		arst_n               = 1'b0;
		in_ch.valid          = 1'b0;
		in_ch.weight         = '0;
		in_ch.value          = '0;
		in_ch.value_unknown  = 1'b0;
		in_ch.window_outside = 1'b0;
		in_ch.last_element   = 1'b0;
		out_ch.ready         = 1'b0;
		win_dot     = 0;
		win_energy  = 0;
		win_unknown = 1'b0;
		win_count   = 0;

		// largest positive ratio, then a negative one just past it that saturates
		queue_element(32767, 16'hFFFF, 0, 0, 1);
		queue_element(-32768, 16'hFFFF, 0, 0, 1);
		// zero energy, with and without an extreme weight
		queue_element(0, 16'h0000, 0, 0, 1);
		queue_element(-32768, 16'h0000, 0, 0, 1);
		// energy but no dot product, then short windows with small dot products
		queue_element(0, 16'hFFFF, 0, 0, 1);
		queue_element(-1, 16'h0001, 0, 0, 1);
		queue_element(1, 16'h0001, 0, 0, 0);
		queue_element(1, 16'h0001, 0, 0, 0);
		queue_element(1, 16'h0001, 0, 0, 1);
		// unknown value early in a window
		queue_element(100, 16'd200, 1, 0, 0);
		queue_element(300, 16'd400, 0, 0, 1);
		// window outside flagged only on the last element
		queue_element(500, 16'd600, 0, 0, 0);
		queue_element(-500, 16'd700, 0, 1, 1);
		queue_element(0, 16'h0000, 1, 0, 1);
		queue_element(32767, 16'hFFFF, 1, 1, 1);
		queue_element(16384, 16'h8000, 0, 0, 1);

		// overlong windows: one with no forced flag, one with a flag forced past the limit
		queue_random_window(WINDOW_LIMIT + 4, -1);
		queue_element(-32768, 16'hFFFF, 0, 0, 0);
		queue_random_window(WINDOW_LIMIT + 1, WINDOW_LIMIT);

		while (elements_queued < RANDOM_ITEMS + 16) begin
			r = $urandom_range(0, 299);
			if (r == 0)
				len = $urandom_range(WINDOW_LIMIT + 1, WINDOW_LIMIT + 12);
			else if (r < 30)
				len = $urandom_range(13, 40);
			else
				len = $urandom_range(1, 12);
			queue_random_window(len, -1);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (elements_taken < elements_queued)
			@(posedge clk);
		while (expected_responses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d elements in %0d windows, %0d past the element limit",
			elements_taken, windows_done, overlong_windows);
		$display("windows: %0d unknown, %0d zero energy, %0d saturated, %0d mismatches",
			unknown_windows, zero_energy_windows, saturated_windows, mismatches);
		if (mismatches == 0)
			$display("[normalized_dot_product_unit] OK");
		else
			$display("[normalized_dot_product_unit] ERROR");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("t=%0t run did not finish", $realtime);
		$display("[normalized_dot_product_unit] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
src/ndp_pkg.sv
src/ndp_if.sv
src/ndp_accum.sv
src/ndp_root_div.sv
src/normalized_dot_product_unit.sv
bench/normalized_dot_product_unit_test.sv
